// ----- rtl/c6502_pkg.sv -----
package c6502_pkg;

    localparam int ADDR_BITS = 16;
    localparam logic [15:0] PC_RESET = 16'hFFFC;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    typedef enum logic [2:0] {
        MODE_ABS  = 3'd0,
        MODE_ABSX = 3'd1,
        MODE_ABSY = 3'd2,
        MODE_ZP   = 3'd3,
        MODE_ZPX  = 3'd4,
        MODE_ZPY  = 3'd5,
        MODE_INDX = 3'd6,
        MODE_INDY = 3'd7
    } mode_t;

    typedef enum logic [3:0] {
        KIND_LDA = 4'd0,
        KIND_LDX = 4'd1,
        KIND_LDY = 4'd2,
        KIND_STA = 4'd3,
        KIND_STX = 4'd4,
        KIND_STY = 4'd5,
        KIND_ADC = 4'd6,
        KIND_SBC = 4'd7,
        KIND_INC = 4'd8,
        KIND_DEC = 4'd9,
        KIND_INX = 4'd10,
        KIND_INY = 4'd11,
        KIND_DEX = 4'd12,
        KIND_DEY = 4'd13
    } kind_t;

    typedef struct packed {
        logic  valid;
        logic  imm;
        logic  implied;
        kind_t kind;
        mode_t mode;
    } decode_t;

    typedef enum logic [2:0] {
        ADDR_HOST = 3'd0,
        ADDR_PC   = 3'd1,
        ADDR_PTR  = 3'd2,
        ADDR_PTR1 = 3'd3,
        ADDR_EA   = 3'd4
    } asel_t;

    typedef enum logic [3:0] {
        LD_NONE  = 4'd0,
        LD_OP    = 4'd1,
        LD_LO    = 4'd2,
        LD_HI    = 4'd3,
        LD_PLO   = 4'd4,
        LD_PHI   = 4'd5,
        LD_EXEC  = 4'd6,
        LD_IMPL  = 4'd7,
        LD_HOSTR = 4'd8
    } load_t;

    typedef struct packed {
        asel_t asel;
        logic  mem_we;
        logic  wsel_host;
        logic  pc_inc;
        load_t load;
        logic  clear_out;
        logic  bad;
    } dp_cmd_t;

    typedef struct packed {
        decode_t dec;
    } dp_stat_t;

    function automatic decode_t decode(input logic [7:0] op);
        decode_t d;
        d = '{valid: 1'b1, imm: 1'b0, implied: 1'b0, kind: KIND_LDA, mode: MODE_ABS};
        unique case (op)
            8'hE8: begin d.implied = 1'b1; d.kind = KIND_INX; end
            8'hC8: begin d.implied = 1'b1; d.kind = KIND_INY; end
            8'hCA: begin d.implied = 1'b1; d.kind = KIND_DEX; end
            8'h88: begin d.implied = 1'b1; d.kind = KIND_DEY; end
            8'hA9: begin d.imm = 1'b1; d.kind = KIND_LDA; end
            8'hA2: begin d.imm = 1'b1; d.kind = KIND_LDX; end
            8'hA0: begin d.imm = 1'b1; d.kind = KIND_LDY; end
            8'h69: begin d.imm = 1'b1; d.kind = KIND_ADC; end
            8'hE9: begin d.imm = 1'b1; d.kind = KIND_SBC; end
            8'hAD: begin d.kind = KIND_LDA; d.mode = MODE_ABS;  end
            8'hBD: begin d.kind = KIND_LDA; d.mode = MODE_ABSX; end
            8'hB9: begin d.kind = KIND_LDA; d.mode = MODE_ABSY; end
            8'hA5: begin d.kind = KIND_LDA; d.mode = MODE_ZP;   end
            8'hB5: begin d.kind = KIND_LDA; d.mode = MODE_ZPX;  end
            8'hA1: begin d.kind = KIND_LDA; d.mode = MODE_INDX; end
            8'hB1: begin d.kind = KIND_LDA; d.mode = MODE_INDY; end
            8'hAE: begin d.kind = KIND_LDX; d.mode = MODE_ABS;  end
            8'hBE: begin d.kind = KIND_LDX; d.mode = MODE_ABSY; end
            8'hA6: begin d.kind = KIND_LDX; d.mode = MODE_ZP;   end
            8'hB6: begin d.kind = KIND_LDX; d.mode = MODE_ZPY;  end
            8'hAC: begin d.kind = KIND_LDY; d.mode = MODE_ABS;  end
            8'hBC: begin d.kind = KIND_LDY; d.mode = MODE_ABSX; end
            8'hA4: begin d.kind = KIND_LDY; d.mode = MODE_ZP;   end
            8'hB4: begin d.kind = KIND_LDY; d.mode = MODE_ZPX;  end
            8'h8D: begin d.kind = KIND_STA; d.mode = MODE_ABS;  end
            8'h9D: begin d.kind = KIND_STA; d.mode = MODE_ABSX; end
            8'h99: begin d.kind = KIND_STA; d.mode = MODE_ABSY; end
            8'h85: begin d.kind = KIND_STA; d.mode = MODE_ZP;   end
            8'h95: begin d.kind = KIND_STA; d.mode = MODE_ZPX;  end
            8'h81: begin d.kind = KIND_STA; d.mode = MODE_INDX; end
            8'h91: begin d.kind = KIND_STA; d.mode = MODE_INDY; end
            8'h8E: begin d.kind = KIND_STX; d.mode = MODE_ABS;  end
            8'h86: begin d.kind = KIND_STX; d.mode = MODE_ZP;   end
            8'h96: begin d.kind = KIND_STX; d.mode = MODE_ZPY;  end
            8'h8C: begin d.kind = KIND_STY; d.mode = MODE_ABS;  end
            8'h84: begin d.kind = KIND_STY; d.mode = MODE_ZP;   end
            8'h94: begin d.kind = KIND_STY; d.mode = MODE_ZPX;  end
            8'h6D: begin d.kind = KIND_ADC; d.mode = MODE_ABS;  end
            8'h7D: begin d.kind = KIND_ADC; d.mode = MODE_ABSX; end
            8'h79: begin d.kind = KIND_ADC; d.mode = MODE_ABSY; end
            8'h65: begin d.kind = KIND_ADC; d.mode = MODE_ZP;   end
            8'h75: begin d.kind = KIND_ADC; d.mode = MODE_ZPX;  end
            8'h61: begin d.kind = KIND_ADC; d.mode = MODE_INDX; end
            8'h71: begin d.kind = KIND_ADC; d.mode = MODE_INDY; end
            8'hED: begin d.kind = KIND_SBC; d.mode = MODE_ABS;  end
            8'hFD: begin d.kind = KIND_SBC; d.mode = MODE_ABSX; end
            8'hF9: begin d.kind = KIND_SBC; d.mode = MODE_ABSY; end
            8'hE5: begin d.kind = KIND_SBC; d.mode = MODE_ZP;   end
            8'hF5: begin d.kind = KIND_SBC; d.mode = MODE_ZPX;  end
            8'hE1: begin d.kind = KIND_SBC; d.mode = MODE_INDX; end
            8'hF1: begin d.kind = KIND_SBC; d.mode = MODE_INDY; end
            8'hEE: begin d.kind = KIND_INC; d.mode = MODE_ABS;  end
            8'hFE: begin d.kind = KIND_INC; d.mode = MODE_ABSX; end
            8'hE6: begin d.kind = KIND_INC; d.mode = MODE_ZP;   end
            8'hF6: begin d.kind = KIND_INC; d.mode = MODE_ZPX;  end
            8'hCE: begin d.kind = KIND_DEC; d.mode = MODE_ABS;  end
            8'hDE: begin d.kind = KIND_DEC; d.mode = MODE_ABSX; end
            8'hC6: begin d.kind = KIND_DEC; d.mode = MODE_ZP;   end
            8'hD6: begin d.kind = KIND_DEC; d.mode = MODE_ZPX;  end
            default: d.valid = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/c6502_req_if.sv -----
interface c6502_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] host_addr;
    logic [7:0]  host_wdata;
    modport source (output valid, cmd, host_addr, host_wdata, input ready);
    modport sink (input valid, cmd, host_addr, host_wdata, output ready);
endinterface

// ----- rtl/c6502_rsp_if.sv -----
interface c6502_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  host_rdata;
    logic [15:0] prog_counter;
    logic [7:0]  acc_value;
    logic [7:0]  x_value;
    logic [7:0]  y_value;
    logic        neg_flag;
    logic        ovf_flag;
    logic        zero_flag;
    logic        carry_flag;
    logic        bad_opcode;
    modport source (output valid, host_rdata, prog_counter, acc_value, x_value, y_value,
        neg_flag, ovf_flag, zero_flag, carry_flag, bad_opcode, input ready);
    modport sink (input valid, host_rdata, prog_counter, acc_value, x_value, y_value,
        neg_flag, ovf_flag, zero_flag, carry_flag, bad_opcode, output ready);
endinterface

// ----- rtl/c6502_datapath.sv -----
module c6502_datapath
    import c6502_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_take,
    input  logic [15:0] host_addr,
    input  logic [7:0]  host_wdata,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic [7:0]  host_rdata,
    output logic [15:0] prog_counter,
    output logic [7:0]  acc_value,
    output logic [7:0]  x_value,
    output logic [7:0]  y_value,
    output logic        neg_flag,
    output logic        ovf_flag,
    output logic        zero_flag,
    output logic        carry_flag,
    output logic        bad_opcode
);

    logic [7:0]  mem [2**ADDR_BITS];
    logic [7:0]  rdata_reg;
    logic [15:0] haddr_reg;
    logic [7:0]  hwdata_reg;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  acc_reg, acc_next, x_reg, x_next, y_reg, y_next;
    logic        n_reg, n_next, v_reg, v_next, z_reg, z_next, c_reg, c_next;
    logic [7:0]  op_reg, lo_reg, rmw_reg;
    logic [15:0] ea_reg;
    logic        bad_reg, bad_next;
    logic [7:0]  hrd_reg, hrd_next;
    logic [15:0] addr;
    logic [7:0]  wdata;
    decode_t     dec;
    logic [7:0]  zpx, zpy, m, r, lres;
    logic [8:0]  sum;
    logic        is_mem_op;

    assign dec = decode(op_reg);
    assign stat.dec = dec;
    assign zpx = lo_reg + x_reg;
    assign zpy = lo_reg + y_reg;

    always_comb
    begin
        unique case (cmd.asel)
            ADDR_HOST: addr = haddr_reg;
            ADDR_PC:   addr = pc_reg;
            ADDR_PTR:  addr = {8'h00, (dec.mode == MODE_INDX) ? zpx : lo_reg};
            ADDR_PTR1: addr = {8'h00, ((dec.mode == MODE_INDX) ? zpx : lo_reg) + 8'd1};
            default:   addr = ea_reg;
        endcase
    end

    always_comb
    begin
        unique case (dec.kind)
            KIND_STX: wdata = x_reg;
            KIND_STY: wdata = y_reg;
            KIND_INC, KIND_DEC: wdata = rmw_reg;
            default:  wdata = acc_reg;
        endcase
        if (cmd.wsel_host)
            wdata = hwdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[addr[ADDR_BITS-1:0]] <= wdata;
        rdata_reg <= mem[addr[ADDR_BITS-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            haddr_reg  <= host_addr;
            hwdata_reg <= host_wdata;
        end
        unique case (cmd.load)
            LD_OP:  op_reg <= rdata_reg;
            LD_LO:  lo_reg <= rdata_reg;
            LD_PLO: lo_reg <= rdata_reg;
            default: ;
        endcase
        if (cmd.load == LD_HI || cmd.load == LD_PHI)
        begin
            unique case (dec.mode)
                MODE_ABSX: ea_reg <= {rdata_reg, lo_reg} + {8'h00, x_reg};
                MODE_ABSY, MODE_INDY: ea_reg <= {rdata_reg, lo_reg} + {8'h00, y_reg};
                default:   ea_reg <= {rdata_reg, lo_reg};
            endcase
        end
        else if (cmd.load == LD_LO)
        begin
            unique case (dec.mode)
                MODE_ZPX: ea_reg <= {8'h00, rdata_reg + x_reg};
                MODE_ZPY: ea_reg <= {8'h00, rdata_reg + y_reg};
                default:  ea_reg <= {8'h00, rdata_reg};
            endcase
        end
        if (cmd.load == LD_EXEC)
            rmw_reg <= (dec.kind == KIND_INC) ? rdata_reg + 8'd1 : rdata_reg - 8'd1;
    end

    assign m   = (dec.kind == KIND_SBC) ? ~rdata_reg : rdata_reg;
    assign sum = {1'b0, acc_reg} + {1'b0, m} + {8'h00, c_reg};
    assign r   = sum[7:0];
    assign is_mem_op = (dec.kind == KIND_INC) || (dec.kind == KIND_DEC);

    always_comb
    begin
        pc_next  = cmd.pc_inc ? pc_reg + 16'd1 : pc_reg;
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        n_next   = n_reg;
        v_next   = v_reg;
        z_next   = z_reg;
        c_next   = c_reg;
        lres     = 8'h00;
        bad_next = bad_reg;
        hrd_next = hrd_reg;
        if (cmd.clear_out)
        begin
            bad_next = 1'b0;
            hrd_next = 8'h00;
        end
        if (cmd.bad)
            bad_next = 1'b1;
        if (cmd.load == LD_HOSTR)
            hrd_next = rdata_reg;
        if (cmd.load == LD_IMPL)
        begin
            unique case (dec.kind)
                KIND_INX: begin x_next = x_reg + 8'd1; lres = x_next; end
                KIND_DEX: begin x_next = x_reg - 8'd1; lres = x_next; end
                KIND_INY: begin y_next = y_reg + 8'd1; lres = y_next; end
                default:  begin y_next = y_reg - 8'd1; lres = y_next; end
            endcase
            n_next = lres[7];
            z_next = (lres == 8'h00);
        end
        if (cmd.load == LD_EXEC)
        begin
            unique case (dec.kind)
                KIND_LDA: begin acc_next = rdata_reg; lres = rdata_reg; end
                KIND_LDX: begin x_next = rdata_reg; lres = rdata_reg; end
                KIND_LDY: begin y_next = rdata_reg; lres = rdata_reg; end
                KIND_ADC, KIND_SBC:
                begin
                    acc_next = r;
                    lres = r;
                    c_next = sum[8];
                    v_next = ~(acc_reg[7] ^ m[7]) & (acc_reg[7] ^ r[7]);
                end
                KIND_INC: lres = rdata_reg + 8'd1;
                KIND_DEC: lres = rdata_reg - 8'd1;
                default: ;
            endcase
            if (dec.kind == KIND_LDA || dec.kind == KIND_LDX || dec.kind == KIND_LDY ||
                dec.kind == KIND_ADC || dec.kind == KIND_SBC || is_mem_op)
            begin
                n_next = lres[7];
                z_next = (lres == 8'h00);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_RESET;
            acc_reg <= 8'h00;
            x_reg   <= 8'h00;
            y_reg   <= 8'h00;
            n_reg   <= 1'b0;
            v_reg   <= 1'b0;
            z_reg   <= 1'b0;
            c_reg   <= 1'b0;
            bad_reg <= 1'b0;
            hrd_reg <= 8'h00;
        end
        else
        begin
            pc_reg  <= pc_next;
            acc_reg <= acc_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            n_reg   <= n_next;
            v_reg   <= v_next;
            z_reg   <= z_next;
            c_reg   <= c_next;
            bad_reg <= bad_next;
            hrd_reg <= hrd_next;
        end
    end

    assign host_rdata   = hrd_reg;
    assign prog_counter = pc_reg;
    assign acc_value    = acc_reg;
    assign x_value      = x_reg;
    assign y_value      = y_reg;
    assign neg_flag     = n_reg;
    assign ovf_flag     = v_reg;
    assign zero_flag    = z_reg;
    assign carry_flag   = c_reg;
    assign bad_opcode   = bad_reg;

endmodule

// ----- rtl/c6502_ctrl.sv -----
module c6502_ctrl
    import c6502_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] req_cmd,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_HOST  = 12'b000000000010,
        ST_FETCH = 12'b000000000100,
        ST_OPW   = 12'b000000001000,
        ST_DEC   = 12'b000000010000,
        ST_LOW   = 12'b000000100000,
        ST_HIGH  = 12'b000001000000,
        ST_PLO   = 12'b000010000000,
        ST_PHI   = 12'b000100000000,
        ST_OPND  = 12'b001000000000,
        ST_EXEC  = 12'b010000000000,
        ST_DONE  = 12'b100000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic       hi_reg, hi_next;
    logic       rmw_reg, rmw_next;
    decode_t    d;

    assign d = stat.dec;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        hi_next    = hi_reg;
        rmw_next   = rmw_reg;
        cmd = '{asel: ADDR_PC, mem_we: 1'b0, wsel_host: 1'b0, pc_inc: 1'b0,
                load: LD_NONE, clear_out: 1'b0, bad: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = req_cmd;
                    cmd.clear_out = 1'b1;
                    state_next = (req_cmd == CMD_EXEC) ? ST_FETCH : ST_HOST;
                end
            end
            ST_HOST:
            begin
                cmd.asel = ADDR_HOST;
                cmd.wsel_host = 1'b1;
                cmd.mem_we = (kind_reg == CMD_WRITE);
                state_next = (kind_reg == CMD_READ) ? ST_OPW : ST_DONE;
            end
            ST_FETCH:
            begin
                cmd.pc_inc = 1'b1;
                hi_next = 1'b0;
                rmw_next = 1'b0;
                state_next = ST_OPW;
            end
            ST_OPW:
            begin
                if (kind_reg == CMD_READ)
                begin
                    cmd.load = LD_HOSTR;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.load = LD_OP;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (!d.valid)
                begin
                    cmd.bad = 1'b1;
                    state_next = ST_DONE;
                end
                else if (d.implied)
                begin
                    cmd.load = LD_IMPL;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.pc_inc = 1'b1;
                    state_next = d.imm ? ST_EXEC : ST_LOW;
                end
            end
            ST_LOW:
            begin
                cmd.load = LD_LO;
                if (d.mode == MODE_ABS || d.mode == MODE_ABSX || d.mode == MODE_ABSY)
                begin
                    cmd.pc_inc = 1'b1;
                    state_next = ST_HIGH;
                end
                else if (d.mode == MODE_INDX || d.mode == MODE_INDY)
                    state_next = ST_PLO;
                else
                    state_next = ST_OPND;
            end
            ST_HIGH:
            begin
                cmd.load = LD_HI;
                state_next = ST_OPND;
            end
            ST_PLO:
            begin
                cmd.asel = ADDR_PTR;
                state_next = ST_PHI;
            end
            ST_PHI:
            begin
                cmd.asel = ADDR_PTR1;
                if (!hi_reg)
                begin
                    cmd.load = LD_PLO;
                    hi_next = 1'b1;
                end
                else
                begin
                    cmd.load = LD_PHI;
                    hi_next = 1'b0;
                    state_next = ST_OPND;
                end
            end
            ST_OPND:
            begin
                cmd.asel = ADDR_EA;
                if (d.kind == KIND_STA || d.kind == KIND_STX || d.kind == KIND_STY)
                begin
                    cmd.mem_we = 1'b1;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.asel = ADDR_EA;
                if (rmw_reg)
                begin
                    cmd.mem_we = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.load = LD_EXEC;
                    if (d.kind == KIND_INC || d.kind == KIND_DEC)
                        rmw_next = 1'b1;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= CMD_WRITE;
            hi_reg    <= 1'b0;
            rmw_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            hi_reg    <= hi_next;
            rmw_reg   <= rmw_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid)) else $error("ready while response pending");
    a_we_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_we && cmd.wsel_host) |-> (kind_reg == CMD_WRITE))
        else $error("host write outside write request");
`endif

endmodule

// ----- rtl/cpu6502_load_store_arith_core.sv -----
// Host reads take longer than host writes; among execute requests the indirect
// modes take longest.
// Requests are handled one at a time; the next is accepted in the cycle after the response.
// The memory is single-ported with a registered read, so each step makes one access.
// Reset: asynchronous, active low; PC to 0xFFFC, A, X, Y and flags to zero.
// Memory contents are not cleared by reset.
module cpu6502_load_store_arith_core
    import c6502_pkg::*;
(
    input logic clk,
    input logic rst_n,
    c6502_req_if.sink   req,
    c6502_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    c6502_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    c6502_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_take     (req.valid && req.ready),
        .host_addr    (req.host_addr),
        .host_wdata   (req.host_wdata),
        .cmd          (cmd),
        .stat         (stat),
        .host_rdata   (rsp.host_rdata),
        .prog_counter (rsp.prog_counter),
        .acc_value    (rsp.acc_value),
        .x_value      (rsp.x_value),
        .y_value      (rsp.y_value),
        .neg_flag     (rsp.neg_flag),
        .ovf_flag     (rsp.ovf_flag),
        .zero_flag    (rsp.zero_flag),
        .carry_flag   (rsp.carry_flag),
        .bad_opcode   (rsp.bad_opcode)
    );

endmodule
